FILE: hw/rtl/obm_pkg.sv
// ----------------------------------------------------------------------------
// obm_pkg - shared types and helpers of the OHLC bar merger
// Item, merged-bar and result types, saturating add and extreme updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obm_pkg;

  // result queue depth; two slots are kept free for an item that gives two
  localparam int unsigned RESULT_DEPTH = 4;

  localparam logic [15:0] WINDOW_SPAN_RST = 16'd2;

  // APB register map (byte address bit 2 selects the register)
  localparam logic REG_WINDOW_SPAN = 1'b0;

  typedef struct packed {
    logic        series_start;
    logic        series_end;
    logic [15:0] tstamp;
    logic [30:0] open;
    logic [30:0] high;
    logic [30:0] low;
    logic [30:0] close;
    logic [31:0] volume;
    logic [31:0] amount;
  } item_t;

  typedef struct packed {
    logic [15:0] first_time;
    logic [30:0] open;
    logic [30:0] high;
    logic [30:0] low;
    logic [30:0] close;
    logic [31:0] volume;
    logic [31:0] amount;
  } group_t;

  typedef struct packed {
    logic [30:0] max_price;
    logic [30:0] min_price;
    logic [31:0] max_volume;
    logic [31:0] min_volume;
  } ext_t;

  typedef struct packed {
    logic signed [16:0] bar_time;
    logic [30:0]        bar_open;
    logic [30:0]        bar_high;
    logic [30:0]        bar_low;
    logic [30:0]        bar_close;
    logic [31:0]        bar_volume;
    logic [31:0]        bar_amount;
    logic               run_last;
    logic [30:0]        peak_price;
    logic [30:0]        floor_price;
    logic [31:0]        peak_volume;
    logic [31:0]        floor_volume;
  } result_t;

  // results handed to the queue for one item: count, then in order
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // fold one merged bar into the series extremes; zero floors mean none yet
  function automatic ext_t ext_update(input ext_t e, input group_t g);
    ext_t r;
    r = e;
    if (g.high > e.max_price) r.max_price = g.high;
    if (e.min_price == '0 || g.low < e.min_price) r.min_price = g.low;
    if (g.volume > e.max_volume) r.max_volume = g.volume;
    if (e.min_volume == '0 || g.volume < e.min_volume) r.min_volume = g.volume;
    return r;
  endfunction

  function automatic result_t make_result(input group_t g, input ext_t e, input logic last);
    result_t     r;
    logic [16:0] t17;
    t17            = {1'b0, g.first_time} - 17'd1;
    r.bar_time     = signed'(t17);
    r.bar_open     = g.open;
    r.bar_high     = g.high;
    r.bar_low      = g.low;
    r.bar_close    = g.close;
    r.bar_volume   = g.volume;
    r.bar_amount   = g.amount;
    r.run_last     = last;
    r.peak_price   = e.max_price;
    r.floor_price  = e.min_price;
    r.peak_volume  = e.max_volume;
    r.floor_volume = e.min_volume;
    return r;
  endfunction

endpackage

FILE: hw/rtl/ohlc_bar_merger_unit.sv
// ----------------------------------------------------------------------------
// ohlc_bar_merger_unit - merges minute price bars into coarser OHLC bars
// Path: an item taken is held in the input stage, merged, then written to the result queue.
// Throughput: one item a cycle while each gives at most one result and the
// output keeps draining; two-result items are bounded by the single output port.
// Reset: group and extremes cleared, window span set to 2, queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ohlc_bar_merger_unit #(
  parameter int unsigned ResultDepth = obm_pkg::RESULT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               series_start_i,
  input  logic               series_end_i,
  input  logic [15:0]        in_time_i,
  input  logic [30:0]        in_open_i,
  input  logic [30:0]        in_high_i,
  input  logic [30:0]        in_low_i,
  input  logic [30:0]        in_close_i,
  input  logic [31:0]        in_volume_i,
  input  logic [31:0]        in_amount_i,

  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] bar_time_o,
  output logic [30:0]        bar_open_o,
  output logic [30:0]        bar_high_o,
  output logic [30:0]        bar_low_o,
  output logic [30:0]        bar_close_o,
  output logic [31:0]        bar_volume_o,
  output logic [31:0]        bar_amount_o,
  output logic               run_last_o,
  output logic [30:0]        peak_price_o,
  output logic [30:0]        floor_price_o,
  output logic [31:0]        peak_volume_o,
  output logic [31:0]        floor_volume_o,

  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // Configuration: one register, window_span, at byte address 0.
  // Only address bit 2 is decoded; anything at bit 2 set is outside the map.
  // --------------------------------------------------------------------------
  logic [15:0] span_q, span_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    span_d = span_q;
    if (cfg_wr && paddr[2] == obm_pkg::REG_WINDOW_SPAN) span_d = pwdata[15:0];
  end

  always_comb begin
    unique case (paddr[2])
      obm_pkg::REG_WINDOW_SPAN: prdata = {16'd0, span_q};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= obm_pkg::WINDOW_SPAN_RST;
    end else begin
      span_q <= span_d;
    end
  end

  // --------------------------------------------------------------------------
  // Input stage. The item waits here until the result queue can take two
  // results (counting this cycle's pop), then it is merged in one pass.
  // Stall only while the stage is full and cannot move on, so a new item
  // follows in the next cycle whenever the queue keeps draining.
  // --------------------------------------------------------------------------
  logic           stage_vld_q, stage_vld_d;
  obm_pkg::item_t stage_q;
  logic           in_acc, advance, room;

  assign advance    = stage_vld_q & room;
  assign in_stall_o = stage_vld_q & ~room;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    stage_vld_d = stage_vld_q;
    if (in_acc)       stage_vld_d = 1'b1;
    else if (advance) stage_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stage_q.series_start <= series_start_i;
      stage_q.series_end   <= series_end_i;
      stage_q.tstamp       <= in_time_i;
      stage_q.open         <= in_open_i;
      stage_q.high         <= in_high_i;
      stage_q.low          <= in_low_i;
      stage_q.close        <= in_close_i;
      stage_q.volume       <= in_volume_i;
      stage_q.amount       <= in_amount_i;
    end
  end

  // --------------------------------------------------------------------------
  // Merge: window test, OHLC fold, saturating sums and series extremes.
  // Gives the finished group (bar outside window) and/or the flushed group
  // (series end), in that order.
  // --------------------------------------------------------------------------
  obm_pkg::push_t push;

  obm_merge_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_q),
    .span_i    (span_q),
    .push_o    (push)
  );

  // --------------------------------------------------------------------------
  // Result queue: decouples the two-result case from the output handshake.
  // --------------------------------------------------------------------------
  obm_pkg::result_t head;

  obm_result_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (~out_stall_i),
    .valid_o (out_valid_o),
    .room_o  (room),
    .head_o  (head)
  );

  assign bar_time_o     = head.bar_time;
  assign bar_open_o     = head.bar_open;
  assign bar_high_o     = head.bar_high;
  assign bar_low_o      = head.bar_low;
  assign bar_close_o    = head.bar_close;
  assign bar_volume_o   = head.bar_volume;
  assign bar_amount_o   = head.bar_amount;
  assign run_last_o     = head.run_last;
  assign peak_price_o   = head.peak_price;
  assign floor_price_o  = head.floor_price;
  assign peak_volume_o  = head.peak_volume;
  assign floor_volume_o = head.floor_volume;

`ifndef SYNTHESIS
  // series end always flushes a group
  a_end_flushes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && stage_q.series_end |-> push.n != 2'd0)
    else $error("series end item gave no result");

  // two results only from an item that ends the series
  a_two_needs_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd2 |-> stage_q.series_end)
    else $error("two results without series end");

  // nothing reaches the queue unless the stage moves on
  a_push_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> push.n == 2'd0)
    else $error("results pushed without an advancing item");
`endif

endmodule

FILE: hw/rtl/obm_merge_core.sv
// ----------------------------------------------------------------------------
// obm_merge_core - group and extreme state of the bar merger
// Merges one item per advance and hands up to two results to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obm_merge_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  obm_pkg::item_t item_i,
  input  logic [15:0]    span_i,
  output obm_pkg::push_t push_o
);

  logic            flag_q, flag_d;
  obm_pkg::group_t grp_q, grp_d;
  obm_pkg::ext_t   ext_q, ext_d;

  logic            flag_eff;
  obm_pkg::ext_t   ext_eff, ext1, ext2;
  obm_pkg::group_t grp_new;
  logic [16:0]     limit;
  logic            merge, emit1;
  obm_pkg::result_t res_fin, res_flush;

  always_comb begin
    // start flag drops the open group and the extremes
    flag_eff = flag_q & ~item_i.series_start;
    ext_eff  = item_i.series_start ? '0 : ext_q;
    limit    = {1'b0, grp_q.first_time} + {1'b0, span_i};
    merge    = flag_eff && ({1'b0, item_i.tstamp} <= limit);
    emit1    = flag_eff && !merge;

    if (merge) begin
      grp_new        = grp_q;
      grp_new.high   = (item_i.high > grp_q.high) ? item_i.high : grp_q.high;
      grp_new.low    = (item_i.low < grp_q.low) ? item_i.low : grp_q.low;
      grp_new.close  = item_i.close;
      grp_new.volume = obm_pkg::sat_add(grp_q.volume, item_i.volume);
      grp_new.amount = obm_pkg::sat_add(grp_q.amount, item_i.amount);
    end else begin
      grp_new.first_time = item_i.tstamp;
      grp_new.open       = item_i.open;
      grp_new.high       = item_i.high;
      grp_new.low        = item_i.low;
      grp_new.close      = item_i.close;
      grp_new.volume     = item_i.volume;
      grp_new.amount     = item_i.amount;
    end

    ext1      = emit1 ? obm_pkg::ext_update(ext_eff, grp_q) : ext_eff;
    ext2      = obm_pkg::ext_update(ext1, grp_new);
    res_fin   = obm_pkg::make_result(grp_q, ext1, ~item_i.series_end);
    res_flush = obm_pkg::make_result(grp_new, ext2, 1'b1);
  end

  always_comb begin
    push_o.n      = advance_i ? (2'(emit1) + 2'(item_i.series_end)) : 2'd0;
    push_o.first  = emit1 ? res_fin : res_flush;
    push_o.second = res_flush;
  end

  always_comb begin
    flag_d = flag_q;
    grp_d  = grp_q;
    ext_d  = ext_q;
    if (advance_i) begin
      flag_d = ~item_i.series_end;
      grp_d  = grp_new;
      ext_d  = item_i.series_end ? ext2 : ext1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      grp_q  <= '0;
      ext_q  <= '0;
    end else begin
      flag_q <= flag_d;
      grp_q  <= grp_d;
      ext_q  <= ext_d;
    end
  end

endmodule

FILE: hw/rtl/obm_result_fifo.sv
// ----------------------------------------------------------------------------
// obm_result_fifo - result queue of the bar merger
// Takes up to two results a cycle, gives one; flags room for two more.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obm_result_fifo #(
  parameter int unsigned Depth = obm_pkg::RESULT_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  obm_pkg::push_t   push_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             room_o,
  output obm_pkg::result_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  obm_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d, wr_inc1, wr_inc2;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_after_pop;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i & valid_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_after_pop = cnt_q - CntW'(pop);
    room_o        = (cnt_after_pop <= CntW'(Depth - 2));
    wr_inc1       = ptr_next(wr_q);
    wr_inc2       = ptr_next(wr_inc1);
    cnt_d         = cnt_after_pop + CntW'(push_i.n);
    rd_d          = pop ? ptr_next(rd_q) : rd_q;
    case (push_i.n)
      2'd1:    wr_d = wr_inc1;
      2'd2:    wr_d = wr_inc2;
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.n == 2'd2) mem_q[wr_inc1] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the OHLC bar merger
// Feeds minute bars through a table of edge cases and then random series.
// Window spans include 0, 2 and 65535. Every merged bar is checked field by
// field against a typed table bar or a model of the grouping, kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // Pressure burst: receiver hold-off length and number of items offered.
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned BURST_ITEMS  = 30;
  // Cycles let pass after the last expected bar. Covers an item still in
  // flight that gives no bar.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS  = 106;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               series_start_i;
  logic               series_end_i;
  logic [15:0]        in_time_i;
  logic [30:0]        in_open_i;
  logic [30:0]        in_high_i;
  logic [30:0]        in_low_i;
  logic [30:0]        in_close_i;
  logic [31:0]        in_volume_i;
  logic [31:0]        in_amount_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [16:0] bar_time_o;
  logic [30:0]        bar_open_o;
  logic [30:0]        bar_high_o;
  logic [30:0]        bar_low_o;
  logic [30:0]        bar_close_o;
  logic [31:0]        bar_volume_o;
  logic [31:0]        bar_amount_o;
  logic               run_last_o;
  logic [30:0]        peak_price_o;
  logic [30:0]        floor_price_o;
  logic [31:0]        peak_volume_o;
  logic [31:0]        floor_volume_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  ohlc_bar_merger_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .series_start_i (series_start_i),
    .series_end_i   (series_end_i),
    .in_time_i      (in_time_i),
    .in_open_i      (in_open_i),
    .in_high_i      (in_high_i),
    .in_low_i       (in_low_i),
    .in_close_i     (in_close_i),
    .in_volume_i    (in_volume_i),
    .in_amount_i    (in_amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bar_time_o     (bar_time_o),
    .bar_open_o     (bar_open_o),
    .bar_high_o     (bar_high_o),
    .bar_low_o      (bar_low_o),
    .bar_close_o    (bar_close_o),
    .bar_volume_o   (bar_volume_o),
    .bar_amount_o   (bar_amount_o),
    .run_last_o     (run_last_o),
    .peak_price_o   (peak_price_o),
    .floor_price_o  (floor_price_o),
    .peak_volume_o  (peak_volume_o),
    .floor_volume_o (floor_volume_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 2 ns clock, first rising edge at 1 ns
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  obm_pkg::result_t bars_due[$];     // merged bars still to come out, oldest first
  obm_pkg::result_t due_bar;
  obm_pkg::result_t seen_bar;
  int      fails;
  int      items_sent;
  int      bars_checked;
  int      spans_tried;
  int      idle_pct;        // sender: chance in 100 of an idle cycle
  int      stall_pct;       // receiver: chance in 100 of a stall cycle
  bit      hold_req;        // ask the receiver for a long hold-off
  int      hold_left;

  // Model of the merger: open group, series extremes, window span.
  logic [15:0]     span_cfg;
  bit              grp_live;
  obm_pkg::group_t grp;
  obm_pkg::ext_t   ext_run;

  // Directed table
  obm_pkg::item_t   dir_items[$];
  bit               dir_typed[$];
  obm_pkg::result_t dir_want[$];

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] clamp_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    if (wide > 33'h0_FFFF_FFFF) return 32'hFFFF_FFFF;
    return wide[31:0];
  endfunction

  // Closes the open group: folds it into the extremes, gives its bar.
  function automatic obm_pkg::result_t close_bar();
    obm_pkg::result_t r;
    if (grp.high > ext_run.max_price) ext_run.max_price = grp.high;
    // a zero floor reads as "nothing yet", so any low replaces it
    if (ext_run.min_price == 31'd0 || grp.low < ext_run.min_price)
      ext_run.min_price = grp.low;
    if (grp.volume > ext_run.max_volume) ext_run.max_volume = grp.volume;
    if (ext_run.min_volume == 32'd0 || grp.volume < ext_run.min_volume)
      ext_run.min_volume = grp.volume;
    r.bar_time     = {1'b0, grp.first_time} - 17'd1;
    r.bar_open     = grp.open;
    r.bar_high     = grp.high;
    r.bar_low      = grp.low;
    r.bar_close    = grp.close;
    r.bar_volume   = grp.volume;
    r.bar_amount   = grp.amount;
    r.run_last     = 1'b0;
    r.peak_price   = ext_run.max_price;
    r.floor_price  = ext_run.min_price;
    r.peak_volume  = ext_run.max_volume;
    r.floor_volume = ext_run.min_volume;
    return r;
  endfunction

  // One minute bar in, zero to two merged bars out (count returned).
  function automatic int fold_minute_bar(input obm_pkg::item_t b,
                                         output obm_pkg::result_t r0,
                                         output obm_pkg::result_t r1);
    logic [16:0] reach;
    int          n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    // start flag drops the open group unemitted; the span is kept
    if (b.series_start) begin
      grp_live = 1'b0;
      grp      = '0;
      ext_run  = '0;
    end
    // window end computed 17 bits wide, no wrap
    reach = {1'b0, grp.first_time} + {1'b0, span_cfg};
    if (grp_live && {1'b0, b.tstamp} <= reach) begin
      if (b.high > grp.high) grp.high = b.high;
      if (b.low < grp.low) grp.low = b.low;
      grp.close  = b.close;
      grp.volume = clamp_sum(grp.volume, b.volume);
      grp.amount = clamp_sum(grp.amount, b.amount);
    end else begin
      if (grp_live) begin
        r0 = close_bar();
        n  = 1;
      end
      grp_live       = 1'b1;
      grp.first_time = b.tstamp;
      grp.open       = b.open;
      grp.high       = b.high;
      grp.low        = b.low;
      grp.close      = b.close;
      grp.volume     = b.volume;
      grp.amount     = b.amount;
    end
    if (b.series_end) begin
      if (n == 0) r0 = close_bar();
      else r1 = close_bar();
      n++;
      grp_live = 1'b0;
    end
    if (n == 1) r0.run_last = 1'b1;
    if (n == 2) r1.run_last = 1'b1;
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic obm_pkg::item_t mk_bar(input bit s, input bit e, input logic [15:0] t,
                                            input logic [30:0] o, input logic [30:0] h,
                                            input logic [30:0] l, input logic [30:0] c,
                                            input logic [31:0] v, input logic [31:0] a);
    obm_pkg::item_t b;
    b.series_start = s;
    b.series_end   = e;
    b.tstamp       = t;
    b.open         = o;
    b.high         = h;
    b.low          = l;
    b.close        = c;
    b.volume       = v;
    b.amount       = a;
    return b;
  endfunction

  // Hand-written bar for table rows; always the last bar of its item.
  function automatic obm_pkg::result_t mk_res(input logic [16:0] t, input logic [30:0] o,
                                              input logic [30:0] h, input logic [30:0] l,
                                              input logic [30:0] c, input logic [31:0] v,
                                              input logic [31:0] a, input logic [30:0] pp,
                                              input logic [30:0] fp, input logic [31:0] pv,
                                              input logic [31:0] fv);
    obm_pkg::result_t r;
    r.bar_time     = t;
    r.bar_open     = o;
    r.bar_high     = h;
    r.bar_low      = l;
    r.bar_close    = c;
    r.bar_volume   = v;
    r.bar_amount   = a;
    r.run_last     = 1'b1;
    r.peak_price   = pp;
    r.floor_price  = fp;
    r.peak_volume  = pv;
    r.floor_volume = fv;
    return r;
  endfunction

  // Field value biased towards zero, all ones and small numbers.
  function automatic logic [31:0] rand_field(input int bits);
    logic [31:0] mask;
    mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'h1 << bits) - 32'h1);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return mask;
      2, 3: return $urandom_range(0, 1000);
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic obm_pkg::item_t rand_bar(input bit s, input bit e, input logic [15:0] t);
    return mk_bar(s, e, t, 31'(rand_field(31)), 31'(rand_field(31)), 31'(rand_field(31)),
                  31'(rand_field(31)), rand_field(32), rand_field(32));
  endfunction

  task automatic add_row(input obm_pkg::item_t b, input bit typed,
                         input obm_pkg::result_t want);
    dir_items.push_back(b);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  // Entered and left at a falling edge. Offers one item, waits for it to be
  // taken, then queues what it should give (typed bar or model output).
  task automatic send_bar(input obm_pkg::item_t b, input bit typed,
                          input obm_pkg::result_t want);
    obm_pkg::result_t r0;
    obm_pkg::result_t r1;
    int      n;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    series_start_i <= b.series_start;
    series_end_i   <= b.series_end;
    in_time_i      <= b.tstamp;
    in_open_i      <= b.open;
    in_high_i      <= b.high;
    in_low_i       <= b.low;
    in_close_i     <= b.close;
    in_volume_i    <= b.volume;
    in_amount_i    <= b.amount;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n = fold_minute_bar(b, r0, r1);
    if (typed) begin
      bars_due.push_back(want);
    end else begin
      if (n > 0) bars_due.push_back(r0);
      if (n > 1) bars_due.push_back(r1);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Entered and left at a falling edge: setup, access, then idle bus.
  task automatic apb_access(input bit wr, input logic [31:0] wd,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {obm_pkg::REG_WINDOW_SPAN, 2'b00};
    pwdata  <= wd;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic span_readback(input logic [15:0] span_want);
    logic [31:0] rd;
    apb_access(1'b0, 32'h0, rd);
    if (rd !== {16'h0, span_want}) begin
      fails++;
      $display("%0t: window_span read expected %h got %h", $time, {16'h0, span_want}, rd);
    end
  endtask

  // Lower valid, wait for every bar owed, then let stragglers settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (bars_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // New span while idle, an optional pressure burst, then random series under the given idling mix.
  task automatic run_phase(input logic [15:0] span, input int idle, input int stall,
                           input bit pressure);
    logic [31:0] rd;
    logic [15:0] t;
    int          sent;
    int          len;
    drain();
    apb_access(1'b1, {16'h0, span}, rd);
    span_cfg = span;
    span_readback(span);
    spans_tried++;
    idle_pct  = idle;
    stall_pct = stall;

    // Long output hold-off with items still offered: the result queue fills
    // and the input has to stall. Every item flushes, so one bar each.
    if (pressure) begin
      hold_req = 1'b1;
      t = 16'($urandom_range(0, 65535));
      for (int k = 0; k < BURST_ITEMS; k++) begin
        send_bar(rand_bar(k == 0, 1'b1, t), 1'b0, '0);
        t = t + 16'd5;
      end
    end

    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        // well-formed series: start on the first bar, end on the last
        len = $urandom_range(1, 10);
        t   = 16'($urandom_range(0, 65535));
        for (int k = 0; k < len; k++) begin
          send_bar(rand_bar(k == 0, k == len - 1, t), 1'b0, '0);
          case ($urandom_range(0, 7))
            0: ;                                         // same minute
            1, 2, 3, 4: t = t + 16'($urandom_range(1, 3));
            5: t = t + span + 16'd1;                     // just past the window
            6: t = t - 16'($urandom_range(1, 5));        // earlier bar
            default: t = 16'($urandom_range(0, 65535));
          endcase
        end
        sent += len;
      end else begin
        // noise: flags and time unrelated to any series
        send_bar(rand_bar(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          16'($urandom_range(0, 65535))), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a counted hold-off when asked for one
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req    <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Bar checker: each bar taken is matched against the oldest one owed
  // --------------------------------------------------------------------------
  task automatic cmp_field(input string f, input logic [31:0] w, input logic [31:0] g);
    if (w !== g) begin
      fails++;
      $display("%0t: %s expected %h got %h", $time, f, w, g);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_bar.bar_time     = bar_time_o;
      seen_bar.bar_open     = bar_open_o;
      seen_bar.bar_high     = bar_high_o;
      seen_bar.bar_low      = bar_low_o;
      seen_bar.bar_close    = bar_close_o;
      seen_bar.bar_volume   = bar_volume_o;
      seen_bar.bar_amount   = bar_amount_o;
      seen_bar.run_last     = run_last_o;
      seen_bar.peak_price   = peak_price_o;
      seen_bar.floor_price  = floor_price_o;
      seen_bar.peak_volume  = peak_volume_o;
      seen_bar.floor_volume = floor_volume_o;
      if (bars_due.size() == 0) begin
        fails++;
        $display("%0t: bar expected none, got time %h open %h", $time,
                 seen_bar.bar_time, seen_bar.bar_open);
      end else begin
        due_bar = bars_due.pop_front();
        cmp_field("bar_time", {15'h0, due_bar.bar_time}, {15'h0, seen_bar.bar_time});
        cmp_field("bar_open", 32'(due_bar.bar_open), 32'(seen_bar.bar_open));
        cmp_field("bar_high", 32'(due_bar.bar_high), 32'(seen_bar.bar_high));
        cmp_field("bar_low", 32'(due_bar.bar_low), 32'(seen_bar.bar_low));
        cmp_field("bar_close", 32'(due_bar.bar_close), 32'(seen_bar.bar_close));
        cmp_field("bar_volume", due_bar.bar_volume, seen_bar.bar_volume);
        cmp_field("bar_amount", due_bar.bar_amount, seen_bar.bar_amount);
        cmp_field("run_last", 32'(due_bar.run_last), 32'(seen_bar.run_last));
        cmp_field("peak_price", 32'(due_bar.peak_price), 32'(seen_bar.peak_price));
        cmp_field("floor_price", 32'(due_bar.floor_price), 32'(seen_bar.floor_price));
        cmp_field("peak_volume", due_bar.peak_volume, seen_bar.peak_volume);
        cmp_field("floor_volume", due_bar.floor_volume, seen_bar.floor_volume);
        bars_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    series_start_i = 1'b0;
    series_end_i   = 1'b0;
    in_time_i      = '0;
    in_open_i      = '0;
    in_high_i      = '0;
    in_low_i       = '0;
    in_close_i     = '0;
    in_volume_i    = '0;
    in_amount_i    = '0;
    out_stall_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fails          = 0;
    items_sent     = 0;
    bars_checked   = 0;
    spans_tried    = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    span_cfg       = obm_pkg::WINDOW_SPAN_RST;
    grp_live       = 1'b0;
    grp            = '0;
    ext_run        = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // span must come up at its reset value
    span_readback(obm_pkg::WINDOW_SPAN_RST);

    // Directed table, span 2. Typed bars only where they are plain to see.
    // all fields at maximum, time zero -> bar time -1, extremes = this bar
    add_row(mk_bar(1, 1, 16'h0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                   31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
            mk_res(17'h1FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                   31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                   31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // all zero at the last time stamp; start clears earlier extremes
    add_row(mk_bar(1, 1, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_res(17'h0FFFE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // group opens; next at the window edge saturates volume and amount
    add_row(mk_bar(1, 0, 100, 10, 50, 5, 20, 32'hFFFF_FFF0, 32'hFFFF_FFF0), 1'b0, '0);
    add_row(mk_bar(0, 0, 102, 11, 60, 3, 21, 32'h20, 32'h20), 1'b0, '0);
    // earlier than the group's first time still merges
    add_row(mk_bar(0, 0, 98, 12, 40, 4, 22, 1, 1), 1'b0, '0);
    // one past the window: finished group out, new one opens
    add_row(mk_bar(0, 0, 103, 30, 35, 25, 33, 7, 7), 1'b0, '0);
    add_row(mk_bar(0, 1, 105, 31, 70, 2, 34, 8, 8), 1'b0, '0);
    // open group dropped by a start flag, never emitted
    add_row(mk_bar(0, 0, 200, 1, 9, 1, 5, 3, 3), 1'b0, '0);
    add_row(mk_bar(1, 0, 300, 2, 8, 2, 6, 4, 4), 1'b0, '0);
    add_row(mk_bar(0, 1, 301, 3, 7, 1, 4, 5, 5), 1'b0, '0);
    // zero low and volume keep the floors at "none"; next bar sets them
    add_row(mk_bar(1, 1, 10, 6, 9, 0, 6, 0, 9), 1'b0, '0);
    add_row(mk_bar(0, 1, 20, 8, 12, 7, 10, 9, 2), 1'b0, '0);
    // finished group and flushed group from one item
    add_row(mk_bar(0, 0, 30, 5, 15, 4, 11, 100, 50), 1'b0, '0);
    add_row(mk_bar(0, 1, 40, 6, 16, 5, 12, 200, 60), 1'b0, '0);
    // window end beyond 16 bits: no wrap, both merge
    add_row(mk_bar(1, 0, 16'hFFFE, 9, 9, 9, 9, 9, 9), 1'b0, '0);
    add_row(mk_bar(0, 1, 16'hFFFF, 8, 10, 8, 8, 1, 1), 1'b0, '0);
    add_row(mk_bar(1, 0, 16'hFFFF, 4, 6, 3, 5, 2, 2), 1'b0, '0);
    add_row(mk_bar(0, 1, 16'h0001, 5, 7, 4, 6, 3, 3), 1'b0, '0);
    // start and end together on an open group
    add_row(mk_bar(0, 0, 500, 1, 2, 1, 2, 1, 1), 1'b0, '0);
    add_row(mk_bar(1, 1, 600, 7, 8, 6, 7, 6, 6), 1'b0, '0);

    for (int i = 0; i < dir_items.size(); i++)
      send_bar(dir_items[i], dir_typed[i], dir_want[i]);

    // Random phases: span extremes and mixes of idling on both sides.
    run_phase(obm_pkg::WINDOW_SPAN_RST, 0, 0, 1'b0);
    run_phase(16'd0, 69, 0, 1'b0);
    run_phase(16'hFFFF, 0, 69, 1'b0);
    run_phase(16'($urandom_range(1, 8)), 37, 37, 1'b0);
    run_phase(16'($urandom_range(0, 65535)), 0, 0, 1'b1);

    drain();
    $display("Covered %0d minute items, %0d merged bars checked, %0d window spans",
             items_sent, bars_checked, spans_tried + 1);
    $display("including time wrap, saturation, discarded groups and a long output hold-off");
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
